// ===== sv/stt_pkg.sv =====
// ----------------------------------------------------------------------------
// stt_pkg
// Shared constants, codes and controller/datapath interface types for the
// signal timeout timer bank.
// ----------------------------------------------------------------------------
package stt_pkg;

	localparam int CHANNELS = 16;
	localparam int IDX_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int CNT_W    = $clog2(CHANNELS + 1);
	localparam int TIME_W   = 32;
	localparam int CH_W     = 4;

	typedef enum logic [1:0] {
		MODE_FIRE  = 2'd0,
		MODE_CLEAR = 2'd1,
		MODE_TICK  = 2'd2,
		MODE_NONE  = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		KIND_STATUS   = 2'd0,
		KIND_CLEARED  = 2'd1,
		KIND_TIMEOUT  = 2'd2,
		KIND_PROGRESS = 2'd3
	} kind_t;

	// one timer record as held in the channel RAM
	typedef struct packed {
		logic [TIME_W-1:0] start;
		logic [TIME_W-1:0] limit;
		logic              prog;
		logic              notice;
	} chan_rec_t;

	localparam int REC_W = $bits(chan_rec_t);

	// controller -> datapath
	typedef struct packed {
		logic             cap;     // capture input request
		logic             look;    // read record of addressed channel
		logic             drop;    // fire/clear update, optional cleared event
		logic             rd_en;   // scan read
		logic [IDX_W-1:0] rd_idx;
		logic             ev_go;   // consume scan evaluation stage
		logic [IDX_W-1:0] ev_idx;
		logic             stat;    // load status result
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		mode_t mode;
		logic  drop_emit;
		logic  ev_emit;
		logic  out_free;
	} sts_t;

endpackage

// ===== sv/signal_timeout_timer_bank_core.sv =====
// ----------------------------------------------------------------------------
// signal_timeout_timer_bank_core
// Bank of one-shot signal timers with fire, clear and tick-scan requests;
// every request ends with a status result.
// ----------------------------------------------------------------------------
//
//  channel  | handshake             | carries
//  ---------+-----------------------+--------------------------------------
//  in       | in_valid / in_ready   | mode, channel, timeout_ms, now_ms, flags
//  out      | out_valid / out_ready | kind, event fields, status bits, last
//  cfg      | cfg_we (no wait)      | cfg_wdata -> clear_notify_enable
//
//  Sequencing: one request at a time. Fire, clear and unused modes go through
//  accept, record lookup, update and status. A tick adds a scan before status:
//  the scan reads one channel record per cycle from the single RAM read port,
//  unless a held result stalls it, pipelined one stage ahead of its evaluation,
//  then drains the evaluation stage and leaves the scan.
//  Reset: armed bits cleared at once, clear_notify_enable set; no clearing
//  pass, record contents are only used while armed.
//  Stalls: results go through one output register; a held result freezes the
//  status step, and an update or scan step with a result to place, until out_ready frees it.
//
// Structure:
//  stt_ctrl  - sequencer (idle, lookup, fire/clear update, scan, status)
//  stt_dp    - request registers, record RAM, armed bits, result register
//  stt_ram   - channel record store, registered read
//
module signal_timeout_timer_bank_core (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic                       cfg_wdata,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [1:0]                 mode,
	input  logic [stt_pkg::CH_W-1:0]   channel,
	input  logic [stt_pkg::TIME_W-1:0] timeout_ms,
	input  logic [stt_pkg::TIME_W-1:0] now_ms,
	input  logic                       want_progress,
	input  logic                       want_timeout_notice,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [1:0]                 kind,
	output logic [stt_pkg::CH_W-1:0]   event_channel,
	output logic [stt_pkg::TIME_W-1:0] event_timeout,
	output logic [stt_pkg::TIME_W-1:0] elapsed_ms,
	output logic                       is_armed,
	output logic                       any_armed,
	output logic                       any_armed_except,
	output logic                       last
);

	import stt_pkg::*;

	cmd_t cmd;
	sts_t sts;

	// sequencer: one request in flight
	stt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// datapath: timer state and result formatting
	stt_dp u_dp (
		.clk                 (clk),
		.arst_n              (arst_n),
		.cmd                 (cmd),
		.sts                 (sts),
		.cfg_we              (cfg_we),
		.cfg_wdata           (cfg_wdata),
		.mode                (mode),
		.channel             (channel),
		.timeout_ms          (timeout_ms),
		.now_ms              (now_ms),
		.want_progress       (want_progress),
		.want_timeout_notice (want_timeout_notice),
		.out_ready           (out_ready),
		.out_valid           (out_valid),
		.kind                (kind),
		.event_channel       (event_channel),
		.event_timeout       (event_timeout),
		.elapsed_ms          (elapsed_ms),
		.is_armed            (is_armed),
		.any_armed           (any_armed),
		.any_armed_except    (any_armed_except),
		.last                (last)
	);

	// a held result is never overwritten by status
	a_stat_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |-> !cmd.stat)
		else $error("status loaded over a pending result");

	// a held result is never overwritten by a scan event
	a_scan_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready && cmd.ev_go) |-> !sts.ev_emit)
		else $error("scan event loaded over a pending result");

	// status load presents a final result next cycle
	a_stat_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.stat |=> (out_valid && last))
		else $error("status result missing or not marked last");

	// only one request in flight
	a_one_request: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("second request accepted while busy");

endmodule

// ===== sv/stt_ram.sv =====
// ----------------------------------------------------------------------------
// stt_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module stt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== sv/stt_dp.sv =====
// ----------------------------------------------------------------------------
// stt_dp
// Datapath: request registers, channel record RAM, armed bits, scan
// evaluation and the result output register.
// ----------------------------------------------------------------------------
module stt_dp (
	input  logic                       clk,
	input  logic                       arst_n,
	input  stt_pkg::cmd_t              cmd,
	output stt_pkg::sts_t              sts,
	input  logic                       cfg_we,
	input  logic                       cfg_wdata,
	input  logic [1:0]                 mode,
	input  logic [stt_pkg::CH_W-1:0]   channel,
	input  logic [stt_pkg::TIME_W-1:0] timeout_ms,
	input  logic [stt_pkg::TIME_W-1:0] now_ms,
	input  logic                       want_progress,
	input  logic                       want_timeout_notice,
	input  logic                       out_ready,
	output logic                       out_valid,
	output logic [1:0]                 kind,
	output logic [stt_pkg::CH_W-1:0]   event_channel,
	output logic [stt_pkg::TIME_W-1:0] event_timeout,
	output logic [stt_pkg::TIME_W-1:0] elapsed_ms,
	output logic                       is_armed,
	output logic                       any_armed,
	output logic                       any_armed_except,
	output logic                       last
);

	import stt_pkg::*;

	// request registers
	mode_t             mode_q;
	logic [CH_W-1:0]   channel_q;
	logic [TIME_W-1:0] tmo_q;
	logic [TIME_W-1:0] now_q;
	logic              wp_q;
	logic              wn_q;

	logic              cne_q;
	logic [CHANNELS-1:0] armed_q;
	logic [CHANNELS-1:0] nz_q;
	logic [TIME_W-1:0] lim_ch_q;

	logic              out_valid_q;
	kind_t             kind_q;
	logic [CH_W-1:0]   ev_ch_q;
	logic [TIME_W-1:0] ev_tmo_q;
	logic [TIME_W-1:0] el_q;
	logic              ia_q;
	logic              aa_q;
	logic              ae_q;
	logic              last_q;

	logic              ch_ok;
	logic [IDX_W-1:0]  ch_idx;
	logic              is_fc;
	logic              clr_hit;
	logic              ram_we;
	logic              ram_re;
	logic [IDX_W-1:0]  ram_raddr;
	chan_rec_t         wr_rec;
	chan_rec_t         rd_rec;
	logic [REC_W-1:0]  rd_raw;
	logic [TIME_W-1:0] ev_el;
	logic              ev_armed;
	logic              ev_expire;
	logic              ev_emit;
	logic              ld_drop;
	logic              ld_ev;
	logic              st_ia;
	logic              st_aa;
	logic              st_ae;

	assign ch_ok   = 32'(channel_q) < 32'(CHANNELS);
	assign ch_idx  = IDX_W'(channel_q);
	assign is_fc   = (mode_q == MODE_FIRE) || (mode_q == MODE_CLEAR);
	assign clr_hit = is_fc && ch_ok && armed_q[ch_idx];

	// record RAM
	assign ram_we    = cmd.drop && (mode_q == MODE_FIRE) && ch_ok;
	assign ram_re    = cmd.look || cmd.rd_en;
	assign ram_raddr = cmd.look ? ch_idx : cmd.rd_idx;
	assign wr_rec    = '{start: now_q, limit: tmo_q, prog: wp_q, notice: wn_q};
	assign rd_rec    = chan_rec_t'(rd_raw);

	stt_ram #(
		.WIDTH (REC_W),
		.DEPTH (CHANNELS)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ch_idx),
		.wdata (REC_W'(wr_rec)),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (rd_raw)
	);

	// scan evaluation of the record held in the RAM read register
	assign ev_el     = now_q - rd_rec.start;
	assign ev_armed  = armed_q[cmd.ev_idx];
	assign ev_expire = ev_armed && (rd_rec.limit != '0) && (rd_rec.limit <= ev_el);
	assign ev_emit   = ev_armed && (ev_expire ? rd_rec.notice : rd_rec.prog);

	assign ld_drop = cmd.drop && clr_hit && cne_q;
	assign ld_ev   = cmd.ev_go && ev_emit;

	// status queries
	always_comb begin
		st_aa = 1'b0;
		st_ae = 1'b0;
		for (int i = 0; i < CHANNELS; i++) begin
			if (armed_q[i] && nz_q[i]) begin
				st_aa = 1'b1;
				if (!(ch_ok && (IDX_W'(i) == ch_idx))) begin
					st_ae = 1'b1;
				end
			end
		end
	end
	assign st_ia = ch_ok && armed_q[ch_idx];

	assign sts.mode      = mode_q;
	assign sts.drop_emit = clr_hit && cne_q;
	assign sts.ev_emit   = ev_emit;
	assign sts.out_free  = !out_valid_q || out_ready;

	// request capture and per-item payload
	always_ff @(posedge clk) begin
		if (cmd.cap) begin
			mode_q    <= mode_t'(mode);
			channel_q <= channel;
			tmo_q     <= timeout_ms;
			now_q     <= now_ms;
			wp_q      <= want_progress;
			wn_q      <= want_timeout_notice;
		end
		if (cmd.drop) begin
			lim_ch_q <= (mode_q == MODE_FIRE) ? tmo_q : rd_rec.limit;
		end
		if (ram_we) begin
			nz_q[ch_idx] <= (tmo_q != '0);
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cne_q       <= 1'b1;
			armed_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				cne_q <= cfg_wdata;
			end
			// fire re-arms the channel it may have just cleared
			if (ram_we) begin
				armed_q[ch_idx] <= 1'b1;
			end else if (cmd.drop && clr_hit) begin
				armed_q[ch_idx] <= 1'b0;
			end
			if (cmd.ev_go && ev_expire) begin
				armed_q[cmd.ev_idx] <= 1'b0;
			end
			if (ld_drop || ld_ev || cmd.stat) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (ld_drop) begin
			kind_q   <= KIND_CLEARED;
			ev_ch_q  <= channel_q;
			ev_tmo_q <= rd_rec.limit;
			el_q     <= '0;
			ia_q     <= 1'b0;
			aa_q     <= 1'b0;
			ae_q     <= 1'b0;
			last_q   <= 1'b0;
		end else if (ld_ev) begin
			kind_q   <= ev_expire ? KIND_TIMEOUT : KIND_PROGRESS;
			ev_ch_q  <= CH_W'(cmd.ev_idx);
			ev_tmo_q <= rd_rec.limit;
			el_q     <= ev_el;
			ia_q     <= 1'b0;
			aa_q     <= 1'b0;
			ae_q     <= 1'b0;
			last_q   <= 1'b0;
		end else if (cmd.stat) begin
			kind_q   <= KIND_STATUS;
			ev_ch_q  <= channel_q;
			ev_tmo_q <= st_ia ? lim_ch_q : '0;
			el_q     <= '0;
			ia_q     <= st_ia;
			aa_q     <= st_aa;
			ae_q     <= st_ae;
			last_q   <= 1'b1;
		end
	end

	assign out_valid        = out_valid_q;
	assign kind             = kind_q;
	assign event_channel    = ev_ch_q;
	assign event_timeout    = ev_tmo_q;
	assign elapsed_ms       = el_q;
	assign is_armed         = ia_q;
	assign any_armed        = aa_q;
	assign any_armed_except = ae_q;
	assign last             = last_q;

endmodule

// ===== sv/stt_ctrl.sv =====
// ----------------------------------------------------------------------------
// stt_ctrl
// Controller: sequences lookup, fire/clear update, channel scan and status,
// and stalls on a full result register.
// ----------------------------------------------------------------------------
module stt_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  stt_pkg::sts_t sts,
	output stt_pkg::cmd_t cmd
);

	import stt_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_LOOK,
		S_DROP,
		S_SCAN,
		S_STAT
	} state_t;

	state_t           state_q;
	logic [CNT_W-1:0] rd_idx_q;
	logic             ev_vld_s1;
	logic [IDX_W-1:0] ev_idx_s1;
	logic             stall;

	// evaluation stage holds while its result cannot be placed
	assign stall = ev_vld_s1 && sts.ev_emit && !sts.out_free;

	always_comb begin
		cmd        = '0;
		cmd.rd_idx = rd_idx_q[IDX_W-1:0];
		cmd.ev_idx = ev_idx_s1;
		in_ready   = (state_q == S_IDLE);
		unique case (state_q)
			S_IDLE: cmd.cap  = in_valid;
			S_LOOK: cmd.look = 1'b1;
			S_DROP: cmd.drop = !sts.drop_emit || sts.out_free;
			S_SCAN: begin
				if (!stall) begin
					cmd.ev_go = ev_vld_s1;
					cmd.rd_en = rd_idx_q < CNT_W'(CHANNELS);
				end
			end
			S_STAT: cmd.stat = sts.out_free;
			default: cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			rd_idx_q  <= '0;
			ev_vld_s1 <= 1'b0;
			ev_idx_s1 <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_LOOK;
					end
				end
				S_LOOK: state_q <= S_DROP;
				S_DROP: begin
					if (cmd.drop) begin
						rd_idx_q  <= '0;
						ev_vld_s1 <= 1'b0;
						state_q   <= (sts.mode == MODE_TICK) ? S_SCAN : S_STAT;
					end
				end
				S_SCAN: begin
					if (!stall) begin
						ev_vld_s1 <= cmd.rd_en;
						ev_idx_s1 <= rd_idx_q[IDX_W-1:0];
						if (cmd.rd_en) begin
							rd_idx_q <= rd_idx_q + CNT_W'(1);
						end
						if (!cmd.rd_en && !ev_vld_s1) begin
							state_q <= S_STAT;
						end
					end
				end
				S_STAT: begin
					if (cmd.stat) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ===== verif/tb.sv =====
// ----------------------------------------------------------------------------
// tb - signal_timeout_timer_bank_core regression
// Drives fire, clear, tick and unused-mode requests with random sender bursts
// and receiver stalls. Every result is checked against a predictor of the
// timer bank that runs on each accepted request, but for st_fixed directed status.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import stt_pkg::*;

	// one request as presented on the input channel
	typedef struct packed {
		mode_t             mode;
		logic [CH_W-1:0]   channel;
		logic [TIME_W-1:0] timeout_ms;
		logic [TIME_W-1:0] now_ms;
		logic              want_progress;
		logic              want_timeout_notice;
	} timer_req_t;

	// one result as seen on the output channel
	typedef struct packed {
		kind_t             kind;
		logic [CH_W-1:0]   ev_ch;
		logic [TIME_W-1:0] ev_tmo;
		logic [TIME_W-1:0] elapsed;
		logic              armed;
		logic              any;
		logic              any_except;
		logic              last;
	} timer_evt_t;

	// directed row; when st_fixed is set the status result is taken from the
	// row itself instead of the predictor
	typedef struct packed {
		mode_t             mode;
		logic [CH_W-1:0]   ch;
		logic [TIME_W-1:0] tmo;
		logic [TIME_W-1:0] now;
		logic              wp;
		logic              wn;
		logic              st_fixed;
		logic [TIME_W-1:0] st_tmo;
		logic              st_armed;
		logic              st_any;
		logic              st_except;
	} dir_row_t;

	localparam int N_DIR = 22;

	// mode, channel, timeout, now, progress, notice | fixed status:
	// fixed, timeout, is_armed, any_armed, any_armed_except
	dir_row_t dir_rows [N_DIR] = '{
		// right after reset: nothing armed anywhere
		'{MODE_CLEAR, 4'd0,  32'h0,        32'h0,        1'b0, 1'b0,
		  1'b1, 32'h0,        1'b0, 1'b0, 1'b0},
		// unused mode with timeout, time and flag bits all high changes nothing
		'{MODE_NONE,  4'd5,  32'hFFFFFFFF, 32'hFFFFFFFF, 1'b1, 1'b1,
		  1'b1, 32'h0,        1'b0, 1'b0, 1'b0},
		// top channel, largest timeout
		'{MODE_FIRE,  4'd15, 32'hFFFFFFFF, 32'h0,        1'b1, 1'b1,
		  1'b1, 32'hFFFFFFFF, 1'b1, 1'b1, 1'b0},
		// zero timeout: armed but invisible to the any queries
		'{MODE_FIRE,  4'd0,  32'h0,        32'h0,        1'b1, 1'b1,
		  1'b1, 32'h0,        1'b1, 1'b1, 1'b1},
		'{MODE_TICK,  4'd0,  32'h0,        32'h1,        1'b0, 1'b0,
		  1'b0, 32'h0,        1'b0, 1'b0, 1'b0},
		// refire of an armed channel reports the clear
		'{MODE_FIRE,  4'd15, 32'd10,       32'd100,      1'b0, 1'b1,
		  1'b0, 32'h0,        1'b0, 1'b0, 1'b0},
		'{MODE_TICK,  4'd15, 32'h0,        32'd109,      1'b0, 1'b0,
		  1'b0, 32'h0,        1'b0, 1'b0, 1'b0},
		// elapsed equal to timeout expires
		'{MODE_TICK,  4'd15, 32'h0,        32'd110,      1'b0, 1'b0,
		  1'b0, 32'h0,        1'b0, 1'b0, 1'b0},
		// start just below the wrap point
		'{MODE_FIRE,  4'd3,  32'd5,        32'hFFFFFFFE, 1'b1, 1'b0,
		  1'b0, 32'h0,        1'b0, 1'b0, 1'b0},
		'{MODE_TICK,  4'd3,  32'h0,        32'd2,        1'b0, 1'b0,
		  1'b0, 32'h0,        1'b0, 1'b0, 1'b0},
		// expiry without notice is silent
		'{MODE_TICK,  4'd3,  32'h0,        32'd3,        1'b0, 1'b0,
		  1'b0, 32'h0,        1'b0, 1'b0, 1'b0},
		'{MODE_FIRE,  4'd7,  32'd1,        32'h0,        1'b0, 1'b0,
		  1'b0, 32'h0,        1'b0, 1'b0, 1'b0},
		'{MODE_CLEAR, 4'd7,  32'h0,        32'h0,        1'b0, 1'b0,
		  1'b0, 32'h0,        1'b0, 1'b0, 1'b0},
		// clear of an idle channel
		'{MODE_CLEAR, 4'd7,  32'h0,        32'h0,        1'b0, 1'b0,
		  1'b0, 32'h0,        1'b0, 1'b0, 1'b0},
		'{MODE_FIRE,  4'd8,  32'h80000000, 32'h7FFFFFFF, 1'b1, 1'b1,
		  1'b0, 32'h0,        1'b0, 1'b0, 1'b0},
		'{MODE_TICK,  4'd8,  32'h0,        32'hFFFFFFFE, 1'b0, 1'b0,
		  1'b0, 32'h0,        1'b0, 1'b0, 1'b0},
		'{MODE_TICK,  4'd8,  32'h0,        32'hFFFFFFFF, 1'b0, 1'b0,
		  1'b0, 32'h0,        1'b0, 1'b0, 1'b0},
		'{MODE_FIRE,  4'd1,  32'd1,        32'd5,        1'b1, 1'b1,
		  1'b0, 32'h0,        1'b0, 1'b0, 1'b0},
		// zero elapsed gives progress
		'{MODE_TICK,  4'd1,  32'h0,        32'd5,        1'b0, 1'b0,
		  1'b0, 32'h0,        1'b0, 1'b0, 1'b0},
		'{MODE_TICK,  4'd1,  32'h0,        32'd6,        1'b0, 1'b0,
		  1'b0, 32'h0,        1'b0, 1'b0, 1'b0},
		// clear the zero-timeout channel
		'{MODE_CLEAR, 4'd0,  32'h0,        32'h0,        1'b0, 1'b0,
		  1'b0, 32'h0,        1'b0, 1'b0, 1'b0},
		// tick ignores its timeout and flag fields
		'{MODE_TICK,  4'd0,  32'hFFFFFFFF, 32'hFFFFFFFF, 1'b1, 1'b1,
		  1'b0, 32'h0,        1'b0, 1'b0, 1'b0}
	};

	// ------------------------------------------------------------------
	// DUT signals, all inputs known from time zero
	// ------------------------------------------------------------------
	logic                clk                 = 1'b0;
	logic                arst_n              = 1'b0;
	logic                cfg_we              = 1'b0;
	logic                cfg_wdata           = 1'b0;
	logic                in_valid            = 1'b0;
	logic                in_ready;
	logic [1:0]          mode                = '0;
	logic [CH_W-1:0]     channel             = '0;
	logic [TIME_W-1:0]   timeout_ms          = '0;
	logic [TIME_W-1:0]   now_ms              = '0;
	logic                want_progress       = 1'b0;
	logic                want_timeout_notice = 1'b0;
	logic                out_valid;
	logic                out_ready           = 1'b0;
	logic [1:0]          kind;
	logic [CH_W-1:0]     event_channel;
	logic [TIME_W-1:0]   event_timeout;
	logic [TIME_W-1:0]   elapsed_ms;
	logic                is_armed;
	logic                any_armed;
	logic                any_armed_except;
	logic                last;

	signal_timeout_timer_bank_core DUT (
		.clk                 (clk),
		.arst_n              (arst_n),
		.cfg_we              (cfg_we),
		.cfg_wdata           (cfg_wdata),
		.in_valid            (in_valid),
		.in_ready            (in_ready),
		.mode                (mode),
		.channel             (channel),
		.timeout_ms          (timeout_ms),
		.now_ms              (now_ms),
		.want_progress       (want_progress),
		.want_timeout_notice (want_timeout_notice),
		.out_valid           (out_valid),
		.out_ready           (out_ready),
		.kind                (kind),
		.event_channel       (event_channel),
		.event_timeout       (event_timeout),
		.elapsed_ms          (elapsed_ms),
		.is_armed            (is_armed),
		.any_armed           (any_armed),
		.any_armed_except    (any_armed_except),
		.last                (last)
	);

	// ------------------------------------------------------------------
	// Predictor state: shadow copy of the timer bank and its register
	// ------------------------------------------------------------------
	bit                timer_armed  [CHANNELS];
	logic [TIME_W-1:0] timer_start  [CHANNELS];
	logic [TIME_W-1:0] timer_limit  [CHANNELS];
	bit                timer_prog   [CHANNELS];
	bit                timer_notice [CHANNELS];
	bit                clear_notify = 1'b1;     // reset value of the register

	timer_evt_t        pending_events [$];      // results still owed by the DUT
	int unsigned       mismatches   = 0;
	int unsigned       burst_left   = 0;        // requests left in current burst
	logic [TIME_W-1:0] sim_ms       = '0;       // free-running time for stimulus
	int unsigned       ready_cyc    = 0;

	function automatic timer_evt_t make_evt(input kind_t k, input int ch,
			input logic [TIME_W-1:0] tmo, input logic [TIME_W-1:0] el,
			input bit ia, input bit aa, input bit ae, input bit fin);
		timer_evt_t ev;
		ev.kind       = k;
		ev.ev_ch      = ch[CH_W-1:0];
		ev.ev_tmo     = tmo;
		ev.elapsed    = el;
		ev.armed      = ia;
		ev.any        = aa;
		ev.any_except = ae;
		ev.last       = fin;
		return ev;
	endfunction

	// disarm a channel; the cleared report only goes out when enabled
	function automatic void drop_timer(input int ch);
		if (timer_armed[ch]) begin
			timer_armed[ch] = 1'b0;
			if (clear_notify)
				pending_events.push_back(make_evt(KIND_CLEARED, ch, timer_limit[ch],
					'0, 1'b0, 1'b0, 1'b0, 1'b0));
		end
	endfunction

	// work out every result of one accepted request, update shadow state
	function automatic void predict_timer_bank(input timer_req_t r);
		int                ch;
		logic [TIME_W-1:0] el;
		bit                aa;
		bit                ae;
		ch = r.channel;
		aa = 1'b0;
		ae = 1'b0;
		case (r.mode)
			MODE_FIRE: begin
				drop_timer(ch);
				timer_armed[ch]  = 1'b1;
				timer_start[ch]  = r.now_ms;
				timer_limit[ch]  = r.timeout_ms;
				timer_prog[ch]   = r.want_progress;
				timer_notice[ch] = r.want_timeout_notice;
			end
			MODE_CLEAR: begin
				drop_timer(ch);
			end
			MODE_TICK: begin
				// ascending scan; expiry wins over progress
				for (int i = 0; i < CHANNELS; i++) begin
					if (timer_armed[i]) begin
						el = r.now_ms - timer_start[i];
						if (timer_limit[i] != 0 && timer_limit[i] <= el) begin
							timer_armed[i] = 1'b0;
							if (timer_notice[i])
								pending_events.push_back(make_evt(KIND_TIMEOUT, i,
									timer_limit[i], el, 1'b0, 1'b0, 1'b0, 1'b0));
						end else if (timer_prog[i]) begin
							pending_events.push_back(make_evt(KIND_PROGRESS, i,
								timer_limit[i], el, 1'b0, 1'b0, 1'b0, 1'b0));
						end
					end
				end
			end
			default: ;
		endcase
		// closing status; zero-timeout channels do not count as armed here
		for (int i = 0; i < CHANNELS; i++) begin
			if (timer_armed[i] && timer_limit[i] != 0) begin
				aa = 1'b1;
				if (i != ch)
					ae = 1'b1;
			end
		end
		pending_events.push_back(make_evt(KIND_STATUS, ch,
			timer_armed[ch] ? timer_limit[ch] : '0, '0, timer_armed[ch], aa, ae, 1'b1));
	endfunction

	// random request: mostly fires and ticks on a slowly advancing clock,
	// with occasional time jumps, huge timeouts and junk in unused fields
	function automatic timer_req_t draw_request();
		timer_req_t  r;
		int unsigned pick;
		int unsigned tpick;
		sim_ms += $urandom_range(0, 6);
		if ($urandom_range(0, 39) == 0)
			sim_ms = $urandom;
		pick  = $urandom_range(0, 99);
		tpick = $urandom_range(0, 9);
		if (pick < 45)
			r.mode = MODE_FIRE;
		else if (pick < 60)
			r.mode = MODE_CLEAR;
		else if (pick < 96)
			r.mode = MODE_TICK;
		else
			r.mode = MODE_NONE;
		r.channel             = CH_W'($urandom_range(0, CHANNELS - 1));
		r.want_progress       = 1'($urandom_range(0, 1));
		r.want_timeout_notice = 1'($urandom_range(0, 1));
		if (tpick == 0)
			r.timeout_ms = '0;
		else if (tpick == 1)
			r.timeout_ms = $urandom;
		else
			r.timeout_ms = $urandom_range(1, 40);
		r.now_ms = (r.mode == MODE_FIRE || r.mode == MODE_TICK) ? sim_ms : $urandom;
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Sender: bursts of back-to-back requests separated by random gaps
	// ------------------------------------------------------------------
	task automatic issue_request(input timer_req_t r, input bit st_fixed,
			input timer_evt_t st_evt);
		int unsigned gap;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 7);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			// now and then a long stretch without any gap
			burst_left = ($urandom_range(0, 7) == 0) ? 48 : $urandom_range(1, 10);
		end
		in_valid            <= 1'b1;
		mode                <= r.mode;
		channel             <= r.channel;
		timeout_ms          <= r.timeout_ms;
		now_ms              <= r.now_ms;
		want_progress       <= r.want_progress;
		want_timeout_notice <= r.want_timeout_notice;
		do
			@(posedge clk);
		while (!in_ready);
		predict_timer_bank(r);
		if (st_fixed)
			pending_events[pending_events.size() - 1] = st_evt;
		burst_left--;
	endtask

	// drop valid and wait until every owed result is back; each request ends
	// in a status result, so the block is idle once the queue drains
	task automatic drain_requests();
		in_valid   <= 1'b0;
		burst_left = 0;
		while (pending_events.size() != 0)
			@(posedge clk);
	endtask

	// one setting of clear_notify_enable: fill the bank, then random traffic
	task automatic run_phase(input bit notify, input int n_items);
		timer_req_t r;
		drain_requests();
		cfg_we    <= 1'b1;
		cfg_wdata <= notify;
		@(posedge clk);
		cfg_we       <= 1'b0;
		clear_notify = notify;
		// arm every channel with progress so the next ticks run full length
		for (int i = 0; i < CHANNELS; i++) begin
			r.mode                = MODE_FIRE;
			r.channel             = CH_W'(i);
			r.timeout_ms          = ($urandom_range(0, 7) == 0) ? '0 : $urandom_range(1, 60);
			r.now_ms              = sim_ms;
			r.want_progress       = 1'b1;
			r.want_timeout_notice = 1'($urandom_range(0, 1));
			issue_request(r, 1'b0, '0);
		end
		for (int i = CHANNELS; i < n_items; i++)
			issue_request(draw_request(), 1'b0, '0);
	endtask

	task automatic check_field(input string name, input logic [TIME_W-1:0] want,
			input logic [TIME_W-1:0] got);
		if (want !== got) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			mismatches++;
		end
	endtask

	// ------------------------------------------------------------------
	// Clock, limit
	// ------------------------------------------------------------------
	initial begin
		forever #1 clk = ~clk;
	end

	// watchdog: a hung run reports fail and stops
	initial begin
		#2000000;
		$display("signal_timeout_timer_bank_core regression: fail");
		$finish;
	end

	// ------------------------------------------------------------------
	// Receiver: checks each accepted result, then picks next out_ready.
	// Stall pattern rotates through four settings: always ready, mostly ready,
	// ready one cycle in five, mostly stalled.
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		timer_evt_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_events.size() == 0) begin
				$error("result with no pending expectation: kind %0d channel %0d",
					kind, event_channel);
				mismatches++;
			end else begin
				want = pending_events.pop_front();
				check_field("kind", want.kind, kind);
				check_field("event_channel", want.ev_ch, event_channel);
				check_field("event_timeout", want.ev_tmo, event_timeout);
				check_field("elapsed_ms", want.elapsed, elapsed_ms);
				check_field("is_armed", want.armed, is_armed);
				check_field("any_armed", want.any, any_armed);
				check_field("any_armed_except", want.any_except, any_armed_except);
				check_field("last", want.last, last);
			end
		end
		ready_cyc++;
		case ((ready_cyc / 97) % 4)
			0:       out_ready <= 1'b1;
			1:       out_ready <= ($urandom_range(0, 3) != 0);
			2:       out_ready <= (ready_cyc % 5 == 0);
			default: out_ready <= ($urandom_range(0, 3) == 0);
		endcase
	end

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------
	initial begin
		timer_req_t r;
		timer_evt_t st;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table at the reset setting of clear_notify_enable
		foreach (dir_rows[i]) begin
			r.mode                = dir_rows[i].mode;
			r.channel             = dir_rows[i].ch;
			r.timeout_ms          = dir_rows[i].tmo;
			r.now_ms              = dir_rows[i].now;
			r.want_progress       = dir_rows[i].wp;
			r.want_timeout_notice = dir_rows[i].wn;
			st = make_evt(KIND_STATUS, dir_rows[i].ch, dir_rows[i].st_tmo, '0,
				dir_rows[i].st_armed, dir_rows[i].st_any, dir_rows[i].st_except, 1'b1);
			issue_request(r, dir_rows[i].st_fixed, st);
		end

		// random part over both register settings
		sim_ms = 32'd1000;
		run_phase(1'b0, 80);
		run_phase(1'b1, 80);
		sim_ms = 32'hFFFFFF00;   // cross the wrap point in this phase
		run_phase(1'b0, 80);
		run_phase(1'b1, 80);

		drain_requests();
		// a full tick scan plus margin for any stray result
		repeat (2 * CHANNELS + 8) @(posedge clk);
		if (mismatches == 0 && pending_events.size() == 0)
			$display("signal_timeout_timer_bank_core regression: pass");
		else
			$display("signal_timeout_timer_bank_core regression: fail");
		$finish;
	end

endmodule

// ===== filelist.f =====
sv/stt_pkg.sv
sv/stt_ram.sv
sv/stt_dp.sv
sv/stt_ctrl.sv
sv/signal_timeout_timer_bank_core.sv
verif/tb.sv
